// ----- rtl/efs_pkg.sv -----
// shared types, constants and mask search functions for the elevator floor scheduler
// no dependencies; imported by efs_ctrl, efs_datapath and elevator_floor_scheduler

package efs_pkg;

  localparam int NUM_FLOORS = 16;
  localparam int FLOOR_W    = 5;

  typedef logic [FLOOR_W-1:0]    floor_t;
  typedef logic [NUM_FLOORS-1:0] mask_t;

  typedef enum logic [1:0] {
    CMD_REQUEST = 2'd0,
    CMD_ARRIVE  = 2'd1,
    CMD_PASS    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    DIR_STAY = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_PICK,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic load;
    logic apply;
    logic pick;
    logic scan;
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_status_t;

  // lowest marked floor, 0 when none
  function automatic floor_t lowest_set(mask_t m);
    floor_t r;
    r = '0;
    for (int i = NUM_FLOORS - 1; i >= 0; i--) begin
      if (m[i]) r = FLOOR_W'(i + 1);
    end
    return r;
  endfunction

  // highest marked floor, 0 when none
  function automatic floor_t highest_set(mask_t m);
    floor_t r;
    r = '0;
    for (int i = 0; i < NUM_FLOORS; i++) begin
      if (m[i]) r = FLOOR_W'(i + 1);
    end
    return r;
  endfunction

  // floors strictly below f
  function automatic mask_t floors_below(floor_t f);
    mask_t r;
    for (int i = 0; i < NUM_FLOORS; i++) begin
      r[i] = (FLOOR_W'(i + 1) < f);
    end
    return r;
  endfunction

  // one-hot mark of floor f (f in range)
  function automatic mask_t floor_bit(floor_t f);
    mask_t r;
    for (int i = 0; i < NUM_FLOORS; i++) begin
      r[i] = (FLOOR_W'(i + 1) == f);
    end
    return r;
  endfunction

endpackage

// ----- rtl/efs_ctrl.sv -----
// sequencer for the elevator floor scheduler: load, apply, pick target, scan
// depends on efs_pkg

module efs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  efs_pkg::dp_status_t status,
  output efs_pkg::dp_cmd_t    cmd
);
  import efs_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = ST_PICK;
      end
      ST_PICK: begin
        cmd.pick   = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        // hold until the result register can take the beat
        if (!status.out_full) begin
          cmd.scan   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/efs_datapath.sv -----
// scheduler state, request mask searches and result register
// depends on efs_pkg; steered by efs_ctrl

module efs_datapath (
  input  logic                clk,
  input  logic                rst,
  input  efs_pkg::dp_cmd_t    cmd,
  output efs_pkg::dp_status_t status,
  input  logic [1:0]          in_command,
  input  efs_pkg::floor_t     in_floor,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic                out_aim,
  output efs_pkg::floor_t     out_stop,
  output logic                out_go_down,
  output logic                out_busy
);
  import efs_pkg::*;

  // scheduler state
  mask_t  pending_mask;
  floor_t position_floor;
  floor_t far_target;
  logic   busy_flag;
  dir_t   travel_direction;

  // captured event
  logic [1:0] cmd_q;
  floor_t     fl_q;
  logic       fl_ok;
  logic       is_req;
  logic       arr_act;
  logic       pick_pending;

  floor_t scan_floor;
  dir_t   heading;
  floor_t pick_floor;
  logic   go_up;
  logic   scan_aim;
  logic   scan_free;
  floor_t scan_stop;

  assign status.out_full = m_tvalid && !m_tready;

  assign go_up = (far_target != '0) && (far_target > position_floor);

  always_comb begin
    if (go_up) begin
      scan_floor = lowest_set(pending_mask & ~floors_below(position_floor));
    end else begin
      scan_floor = highest_set(pending_mask &
                               (floors_below(position_floor) | floor_bit(position_floor)));
    end
    // no target compares as below every floor
    heading    = ((far_target == '0) || (position_floor > far_target)) ? DIR_DOWN : DIR_UP;
    pick_floor = (travel_direction == DIR_UP) ? highest_set(pending_mask)
                                              : lowest_set(pending_mask);
    // a request always gets a stop, an arrival only when something is still marked
    scan_aim  = is_req || (arr_act && (scan_floor != '0));
    scan_free = arr_act && (scan_floor == '0);
    if (is_req && (scan_floor == '0)) begin
      scan_stop = fl_q;
    end else if (scan_aim) begin
      scan_stop = scan_floor;
    end else begin
      scan_stop = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_mask     <= '0;
      position_floor   <= FLOOR_W'(1);
      far_target       <= '0;
      busy_flag        <= 1'b0;
      travel_direction <= DIR_STAY;
      m_tvalid         <= 1'b0;
      is_req           <= 1'b0;
      arr_act          <= 1'b0;
      pick_pending     <= 1'b0;
    end else begin
      if (cmd.scan) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (cmd.apply) begin
        is_req       <= fl_ok && (cmd_q == CMD_REQUEST);
        arr_act      <= fl_ok && (cmd_q == CMD_ARRIVE) && busy_flag;
        pick_pending <= fl_ok && (cmd_q == CMD_ARRIVE) && busy_flag && (fl_q == far_target);
        if (fl_ok) begin
          case (cmd_q)
            CMD_REQUEST: begin
              busy_flag    <= 1'b1;
              pending_mask <= pending_mask | floor_bit(fl_q);
              if ((far_target == '0) ||
                  (travel_direction == DIR_UP && fl_q > far_target) ||
                  (travel_direction == DIR_DOWN && fl_q < far_target)) begin
                far_target <= fl_q;
              end
            end
            CMD_ARRIVE: begin
              if (busy_flag) begin
                position_floor <= fl_q;
                pending_mask   <= pending_mask & ~floor_bit(fl_q);
                if (fl_q == far_target) begin
                  far_target <= '0;
                end
              end
            end
            CMD_PASS: begin
              position_floor <= fl_q;
            end
            default: ;
          endcase
        end
      end

      // new far target from the cleared mask; stays empty when nothing is marked
      if (cmd.pick && pick_pending) begin
        far_target <= pick_floor;
      end

      if (cmd.scan) begin
        out_aim     <= scan_aim;
        out_stop    <= scan_stop;
        out_go_down <= scan_aim ? (heading == DIR_DOWN) : (travel_direction == DIR_DOWN);
        out_busy    <= busy_flag && !scan_free;
        if (scan_aim) begin
          travel_direction <= heading;
        end
        if (scan_free) begin
          busy_flag <= 1'b0;
        end
      end
    end
  end

  // event capture, payload only
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q <= in_command;
      fl_q  <= in_floor;
      fl_ok <= (in_floor != '0) && (in_floor <= FLOOR_W'(NUM_FLOORS));
    end
  end

endmodule

// ----- rtl/elevator_floor_scheduler.sv -----
// top level of the elevator floor scheduler: stream ports, sequencer and datapath
// depends on efs_pkg, efs_ctrl and efs_datapath

// One floor event is taken per beat on the slave side and exactly one result beat
// leaves on the master side for it. From acceptance to result each event goes through
// these steps in order: one to capture, one to update the request mask, position and far
// target, one to pick a new far target after arrival at the old one, and one to scan the
// request mask for the nearest marked floor and load the result register. The mask
// searches are priority encoders over all floors, so the steps do not depend on the
// number of floors. A result waiting in the result register does not block the
// next event from being accepted; only its final scan step waits for the register.
module elevator_floor_scheduler (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [4:0] floor_number, [7:5] zero
  input  logic [1:0] s_tuser,   // [1:0] command
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [4:0] next_stop, [5] go_down, [6] is_busy, [7] zero
  output logic       m_tuser    // [0] aim_issued
);
  import efs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  floor_t     out_stop;
  logic       out_aim;
  logic       out_go_down;
  logic       out_busy;
  logic       unused_pad;

  // upper pad bits of the input beat carry nothing
  assign unused_pad = ^s_tdata[7:5];

  efs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  efs_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_command  (s_tuser),
    .in_floor    (s_tdata[4:0]),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .out_aim     (out_aim),
    .out_stop    (out_stop),
    .out_go_down (out_go_down),
    .out_busy    (out_busy)
  );

  // result beat packing
  assign m_tdata = {1'b0, out_busy, out_go_down, out_stop};
  assign m_tuser = out_aim;

endmodule

// ----- test/elevator_floor_scheduler_tb.sv -----
// self-checking bench for elevator_floor_scheduler: floor events in, one stop beat out per event
// depends on efs_pkg for floor, mask, command and direction types; predicts every result beat

module elevator_floor_scheduler_tb;
  import efs_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;   // command code the block ignores
  localparam int EVENT_TARGET = 600;          // floor events sent in total
  localparam int TAIL_ITEMS   = 80;           // last events run with no idling on either side
  localparam int DRAIN_CYCLES = 24;           // idle time after the last result beat

  typedef struct packed {
    logic [1:0] cmd;
    floor_t     fl;
  } floor_event_t;

  typedef struct packed {
    mask_t  pending;
    floor_t here;
    floor_t target;     // 0 means no far target
    logic   busy;
    dir_t   heading;
  } car_state_t;

  typedef struct packed {
    logic   aim;
    floor_t stop;
    logic   down;
    logic   busy;
  } stop_reply_t;

  typedef struct packed {
    car_state_t  after;
    stop_reply_t reply;
  } car_step_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tuser;

  floor_event_t feed_q[$];
  stop_reply_t  due_replies[$];
  car_state_t   car, plan;
  floor_t       plan_stop;
  int           total_items, events_in, errors;
  int           n_req, n_arr, n_pass, n_other, n_aims;
  int           send_gap, send_calm, take_gap, take_calm;
  logic         in_taken = 1'b0;

  elevator_floor_scheduler i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor of the car scheduler
  // ---------------------------------------------------------------------------

  // a missing far target compares as a floor below the ground floor
  function automatic int target_rank(floor_t t);
    return (t == '0) ? -1 : int'(t);
  endfunction

  // nearest marked floor from the current one, toward the far target; 0 if none
  function automatic floor_t nearest_marked(car_state_t s);
    floor_t r;
    int     here;
    r = '0;
    here = int'(s.here);
    if (target_rank(s.target) > here) begin
      for (int f = NUM_FLOORS; f >= here; f--) begin
        if (s.pending[f-1]) r = floor_t'(f);
      end
    end else begin
      for (int f = 1; f <= here; f++) begin
        if (s.pending[f-1]) r = floor_t'(f);
      end
    end
    return r;
  endfunction

  function automatic dir_t heading_to(car_state_t s);
    return (int'(s.here) > target_rank(s.target)) ? DIR_DOWN : DIR_UP;
  endfunction

  function automatic car_step_t advance_car(car_state_t s, logic [1:0] cmd, floor_t fl);
    car_step_t o;
    int        fi;
    int        tv;
    floor_t    n;
    o.after = s;
    o.reply = '0;
    fi = int'(fl);
    if (fi >= 1 && fi <= NUM_FLOORS) begin
      case (cmd)
        CMD_REQUEST: begin
          tv = target_rank(o.after.target);
          o.after.busy = 1'b1;
          o.after.pending[fi-1] = 1'b1;
          // a request beyond the far target in the current heading extends the sweep
          if (tv == -1 || (o.after.heading == DIR_UP && fi > tv) ||
              (o.after.heading == DIR_DOWN && fi < tv)) begin
            o.after.target = fl;
          end
          n = nearest_marked(o.after);
          o.reply.stop = (n != '0) ? n : fl;
          o.after.heading = heading_to(o.after);
          o.reply.aim = 1'b1;
        end
        CMD_ARRIVE: begin
          if (o.after.busy) begin
            o.after.here = fl;
            o.after.pending[fi-1] = 1'b0;
            if (fi == target_rank(o.after.target)) begin
              // end of sweep: highest mark when going up, else lowest
              o.after.target = '0;
              if (o.after.heading == DIR_UP) begin
                for (int f = 1; f <= NUM_FLOORS; f++) begin
                  if (o.after.pending[f-1]) o.after.target = floor_t'(f);
                end
              end else begin
                for (int f = NUM_FLOORS; f >= 1; f--) begin
                  if (o.after.pending[f-1]) o.after.target = floor_t'(f);
                end
              end
            end
            n = nearest_marked(o.after);
            if (n != '0) begin
              o.after.heading = heading_to(o.after);
              o.reply.stop = n;
              o.reply.aim = 1'b1;
            end else begin
              o.after.busy = 1'b0;
            end
          end
        end
        CMD_PASS: begin
          o.after.here = fl;
        end
        default: ;
      endcase
    end
    o.reply.down = (o.after.heading == DIR_DOWN);
    o.reply.busy = o.after.busy;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus planning, with a shadow car so that arrivals follow commanded stops
  // ---------------------------------------------------------------------------

  task automatic add_event(logic [1:0] c, floor_t f);
    car_step_t o;
    o = advance_car(plan, c, f);
    plan = o.after;
    if (o.reply.aim) plan_stop = o.reply.stop;
    feed_q.push_back({c, f});
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // event driver: falling edge, random bursts of idle cycles
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    floor_event_t ev;
    if (!rst && (!s_tvalid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (feed_q.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (events_in + TAIL_ITEMS < total_items && send_calm == 0 &&
                   $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 10);
        if ($urandom_range(0, 2) == 0) send_calm = $urandom_range(10, 40);
        s_tvalid <= 1'b0;
      end else begin
        ev = feed_q.pop_front();
        if (send_calm > 0) send_calm--;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, ev.fl};
        s_tuser  <= ev.cmd;
      end
    end
  end

  // result sink: stalls in bursts the same way
  always @(negedge clk) begin
    if (!rst) begin
      if (take_gap > 0) begin
        take_gap--;
        m_tready <= 1'b0;
      end else if (events_in + TAIL_ITEMS < total_items && take_calm == 0 &&
                   $urandom_range(0, 5) == 0) begin
        take_gap = $urandom_range(0, 10);
        if ($urandom_range(0, 2) == 0) take_calm = $urandom_range(10, 40);
        m_tready <= 1'b0;
      end else begin
        if (take_calm > 0) take_calm--;
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: rising edge; check the result beat first, then predict the new event
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    stop_reply_t want;
    car_step_t   step;
    in_taken <= s_tvalid && s_tready && !rst;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (due_replies.size() == 0) begin
          $error("result beat with no event waiting for one");
          errors++;
        end else begin
          want = due_replies.pop_front();
          check_field("aim_issued", want.aim, m_tuser);
          check_field("next_stop", want.stop, m_tdata[4:0]);
          check_field("go_down", want.down, m_tdata[5]);
          check_field("is_busy", want.busy, m_tdata[6]);
          if (m_tuser) n_aims++;
        end
      end
      if (s_tvalid && s_tready) begin
        step = advance_car(car, s_tuser, s_tdata[4:0]);
        car = step.after;
        due_replies.push_back(step.reply);
        events_in++;
        case (s_tuser)
          CMD_REQUEST: n_req++;
          CMD_ARRIVE:  n_arr++;
          CMD_PASS:    n_pass++;
          default:     n_other++;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int     pick;
    floor_t hop;
    car = '{pending: '0, here: floor_t'(1), target: '0, busy: 1'b0, heading: DIR_STAY};
    plan = car;
    plan_stop = '0;

    // ignored events: bad command, floors 0 and above the top, arrival while free
    add_event(CMD_UNUSED, 5'd5);
    add_event(CMD_REQUEST, 5'd0);
    add_event(CMD_REQUEST, 5'd17);
    add_event(CMD_REQUEST, 5'd31);
    add_event(CMD_ARRIVE, 5'd4);
    add_event(CMD_PASS, 5'd0);
    // first request sets the far target, a second one behind it does not
    add_event(CMD_PASS, 5'd3);
    add_event(CMD_REQUEST, 5'd1);
    add_event(CMD_REQUEST, 5'd16);
    add_event(CMD_PASS, 5'd2);
    // reaching the target turns the sweep around
    add_event(CMD_ARRIVE, 5'd1);
    add_event(CMD_PASS, 5'd8);
    add_event(CMD_REQUEST, 5'd5);
    add_event(CMD_ARRIVE, 5'd12);
    add_event(CMD_ARRIVE, 5'd16);
    add_event(CMD_REQUEST, 5'd31);
    add_event(CMD_ARRIVE, 5'd5);
    add_event(CMD_ARRIVE, 5'd9);
    add_event(CMD_REQUEST, 5'd16);
    add_event(CMD_REQUEST, 5'd2);
    add_event(CMD_ARRIVE, 5'd16);
    add_event(CMD_PASS, 5'd31);
    add_event(CMD_ARRIVE, 5'd2);
    add_event(CMD_UNUSED, 5'd31);

    // random part: mostly a car travelling floor by floor to its commanded stops
    while (feed_q.size() < EVENT_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        add_event(CMD_REQUEST, floor_t'($urandom_range(1, NUM_FLOORS)));
      end else if (pick < 62) begin
        if (!plan.busy) begin
          add_event(CMD_REQUEST, floor_t'($urandom_range(1, NUM_FLOORS)));
        end else if (plan.here < plan_stop) begin
          hop = plan.here + 1'b1;
          add_event((hop == plan_stop) ? CMD_ARRIVE : CMD_PASS, hop);
        end else if (plan.here > plan_stop) begin
          hop = plan.here - 1'b1;
          add_event((hop == plan_stop) ? CMD_ARRIVE : CMD_PASS, hop);
        end else begin
          add_event(CMD_ARRIVE, plan_stop);
        end
      end else if (pick < 74) begin
        add_event(CMD_ARRIVE, (plan_stop == '0) ? floor_t'($urandom_range(1, NUM_FLOORS))
                                                : plan_stop);
      end else if (pick < 84) begin
        add_event(CMD_ARRIVE, floor_t'($urandom_range(1, NUM_FLOORS)));
      end else if (pick < 92) begin
        add_event(CMD_PASS, floor_t'($urandom_range(1, NUM_FLOORS)));
      end else begin
        add_event(2'($urandom_range(0, 3)), floor_t'($urandom_range(0, 31)));
      end
    end
    total_items = feed_q.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (events_in < total_items) @(negedge clk);
    while (due_replies.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d floor events: %0d requests, %0d arrivals, %0d passes, %0d bad codes",
             events_in, n_req, n_arr, n_pass, n_other);
    $display("the car was sent to %0d stops, under random idling on both sides", n_aims);
    if (errors == 0) begin
      $display("elevator_floor_scheduler_tb OK");
    end else begin
      $display("elevator_floor_scheduler_tb NOT OK");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("elevator_floor_scheduler_tb NOT OK");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/efs_pkg.sv
rtl/efs_ctrl.sv
rtl/efs_datapath.sv
rtl/elevator_floor_scheduler.sv
test/elevator_floor_scheduler_tb.sv
